FILE: rtl/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants of the I2C register transfer master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  localparam int unsigned ByteW = 8;

  // bit counter: 0..7 data bits, 8 is the ack clock
  localparam logic [3:0] BitLast = 4'd7;
  localparam logic [3:0] AckSlot = 4'd8;

  localparam logic [ByteW-1:0] DevAddrReset = 8'h64;

  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_RESTART = 3'd1,
    KIND_BIT     = 3'd2,
    KIND_ACKCLK  = 3'd3,
    KIND_RDBIT   = 3'd4,
    KIND_MACK    = 3'd5,
    KIND_STOP    = 3'd6
  } slot_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_START,
    ST_DEV,
    ST_REG,
    ST_RESTART,
    ST_RDADDR,
    ST_RDBITS,
    ST_MACK,
    ST_WRDATA,
    ST_STOP
  } seq_state_e;

  // one captured input item
  typedef struct packed {
    logic             cmd;
    logic             first;
    logic             final_byte;
    logic [ByteW-1:0] reg_addr;
    logic [ByteW-1:0] wr_byte;
    logic [ByteW-1:0] smp_bits;
  } item_t;

  // control of the byte shifter
  typedef struct packed {
    logic             load;
    logic             rotate;
    logic [ByteW-1:0] data;
  } shift_ctl_t;

  // one bus slot on its way to the output register
  typedef struct packed {
    logic             valid;
    slot_kind_e       kind;
    logic             sda;
    logic             drv;
    logic [ByteW-1:0] rbyte;
    logic             rvalid;
    logic             last;
  } slot_t;

endpackage

FILE: rtl/i2crm_shift.sv
// ----------------------------------------------------------------------------
// i2crm_shift
// Byte shifter: loads a byte and rotates it left one bit per slot, MSB out.
// ----------------------------------------------------------------------------
module i2crm_shift (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  i2crm_pkg::shift_ctl_t  ctl_i,
  output logic                   msb_o,
  output logic [7:0]             val_o
);
  import i2crm_pkg::*;

  logic [ByteW-1:0] sr_q, sr_d;

  // rotation brings the byte back whole after eight bits
  always_comb begin
    sr_d = sr_q;
    if (ctl_i.load) begin
      sr_d = ctl_i.data;
    end else if (ctl_i.rotate) begin
      sr_d = {sr_q[ByteW-2:0], sr_q[ByteW-1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= '0;
    end else begin
      sr_q <= sr_d;
    end
  end

  assign msb_o = sr_q[ByteW-1];
  assign val_o = sr_q;

endmodule

FILE: rtl/i2crm_seq.sv
// ----------------------------------------------------------------------------
// i2crm_seq
// Slot sequencer: one phase per state, one slot per cycle unless stalled.
// ----------------------------------------------------------------------------
module i2crm_seq (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic                   adv_i,
  input  i2crm_pkg::item_t       item_i,
  input  logic [7:0]             dev_addr_i,
  input  logic                   msb_i,
  input  logic [7:0]             sr_val_i,
  output logic                   idle_o,
  output i2crm_pkg::shift_ctl_t  shift_o,
  output i2crm_pkg::slot_t       slot_o
);
  import i2crm_pkg::*;

  seq_state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       open_q, open_d;
  logic       rd_q, rd_d;
  logic       ack_slot;

  assign ack_slot = (cnt_q == AckSlot);

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    open_d  = open_q;
    rd_d    = rd_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cnt_d = '0;
        if (item_i.first) begin
          state_d = ST_START;
        end else if (open_q) begin
          state_d = rd_q ? ST_RDBITS : ST_WRDATA;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_START: begin
        if (adv_i) state_d = ST_DEV;
      end
      ST_DEV, ST_REG, ST_RDADDR, ST_WRDATA: begin
        if (adv_i) begin
          if (ack_slot) begin
            cnt_d = '0;
            case (state_q)
              ST_DEV:  state_d = ST_REG;
              ST_REG: begin
                open_d  = 1'b1;
                rd_d    = !item_i.cmd;
                state_d = item_i.cmd ? ST_WRDATA : ST_RESTART;
              end
              ST_RDADDR: state_d = ST_RDBITS;
              default:   state_d = item_i.final_byte ? ST_STOP : ST_IDLE;
            endcase
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end
      ST_RESTART: begin
        if (adv_i) state_d = ST_RDADDR;
      end
      ST_RDBITS: begin
        if (adv_i) begin
          if (cnt_q == BitLast) begin
            cnt_d   = '0;
            state_d = ST_MACK;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end
      ST_MACK: begin
        if (adv_i) state_d = item_i.final_byte ? ST_STOP : ST_IDLE;
      end
      ST_STOP: begin
        if (adv_i) begin
          open_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    slot_o  = '0;
    shift_o = '0;
    idle_o  = (state_q == ST_IDLE);
    case (state_q)
      ST_LOAD: begin
        shift_o.load = 1'b1;
        shift_o.data = rd_q ? item_i.smp_bits : item_i.wr_byte;
      end
      ST_START: begin
        slot_o.valid = 1'b1;
        slot_o.kind  = open_q ? KIND_RESTART : KIND_START;
        slot_o.drv   = 1'b1;
        shift_o.load = adv_i;
        shift_o.data = dev_addr_i;
      end
      ST_DEV, ST_REG, ST_RDADDR, ST_WRDATA: begin
        slot_o.valid = 1'b1;
        if (ack_slot) begin
          slot_o.kind  = KIND_ACKCLK;
          slot_o.sda   = 1'b1;
          slot_o.last  = (state_q == ST_WRDATA) && !item_i.final_byte;
          shift_o.load = adv_i && (state_q != ST_WRDATA);
          case (state_q)
            ST_DEV:    shift_o.data = item_i.reg_addr;
            ST_REG:    shift_o.data = item_i.wr_byte;
            ST_RDADDR: shift_o.data = item_i.smp_bits;
            default:   shift_o.data = '0;
          endcase
        end else begin
          slot_o.kind    = KIND_BIT;
          slot_o.sda     = msb_i;
          slot_o.drv     = 1'b1;
          shift_o.rotate = adv_i;
        end
      end
      ST_RESTART: begin
        slot_o.valid = 1'b1;
        slot_o.kind  = KIND_RESTART;
        slot_o.drv   = 1'b1;
        shift_o.load = adv_i;
        shift_o.data = dev_addr_i + 8'd1;
      end
      ST_RDBITS: begin
        slot_o.valid   = 1'b1;
        slot_o.kind    = KIND_RDBIT;
        slot_o.sda     = msb_i;
        shift_o.rotate = adv_i;
      end
      ST_MACK: begin
        slot_o.valid  = 1'b1;
        slot_o.kind   = KIND_MACK;
        slot_o.sda    = item_i.final_byte;
        slot_o.drv    = 1'b1;
        slot_o.rbyte  = sr_val_i;
        slot_o.rvalid = 1'b1;
        slot_o.last   = !item_i.final_byte;
      end
      ST_STOP: begin
        slot_o.valid = 1'b1;
        slot_o.kind  = KIND_STOP;
        slot_o.sda   = 1'b1;
        slot_o.drv   = 1'b1;
        slot_o.last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      open_q  <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      open_q  <= open_d;
      rd_q    <= rd_d;
    end
  end

endmodule

FILE: rtl/i2c_register_transfer_master.sv
// ----------------------------------------------------------------------------
// i2c_register_transfer_master
// I2C master for register reads and writes, one bus slot per output item.
// ----------------------------------------------------------------------------
// Each input item carries one data byte; the block answers with one output
// item per bus slot (start, bit, ack clock, stop and so on). An item is taken
// only while the sequencer is idle and occupies it through accept, decode and
// the slots it causes: 9 or 10 slots for a continuation item, 28 or 29 for an
// opening write, 38 or 39 for an opening read. Slots leave one per cycle
// through the output register while tready is high; a slot that waits in
// that register with tready low holds the sequencer. Bytes move through a
// single 8-bit rotating shifter, one bit per slot.
// ----------------------------------------------------------------------------
module i2c_register_transfer_master (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // register_address, write_byte, sampled_bits
  input  logic [1:0]  s_axis_tuser,  // cmd, first_byte
  input  logic        s_axis_tlast,  // final_byte
  // output items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // sda_level, master_drives, read_byte, zero pad
  output logic [3:0]  m_axis_tuser,  // slot_kind[2:0], read_valid
  output logic        m_axis_tlast   // last
);
  import i2crm_pkg::*;

  logic [ByteW-1:0] dev_q;
  item_t            item_q;
  logic             accept;
  logic             adv;
  logic             idle;
  logic             msb;
  logic [ByteW-1:0] sr_val;
  shift_ctl_t       shift_ctl;
  slot_t            slot;
  slot_t            out_q;
  logic             out_valid_q;

  // register file
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, dev_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= DevAddrReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      dev_q <= pwdata[ByteW-1:0];
    end
  end

  // item capture
  assign s_axis_tready = idle;
  assign accept        = s_axis_tvalid && idle;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.cmd        <= s_axis_tuser[0];
      item_q.first      <= s_axis_tuser[1];
      item_q.final_byte <= s_axis_tlast;
      item_q.reg_addr   <= s_axis_tdata[7:0];
      item_q.wr_byte    <= s_axis_tdata[15:8];
      item_q.smp_bits   <= s_axis_tdata[23:16];
    end
  end

  assign adv = !out_valid_q || m_axis_tready;

  i2crm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .adv_i      (adv),
    .item_i     (item_q),
    .dev_addr_i (dev_q),
    .msb_i      (msb),
    .sr_val_i   (sr_val),
    .idle_o     (idle),
    .shift_o    (shift_ctl),
    .slot_o     (slot)
  );

  i2crm_shift u_shift (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (shift_ctl),
    .msb_o  (msb),
    .val_o  (sr_val)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= slot.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && slot.valid) begin
      out_q <= slot;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.rbyte, out_q.drv, out_q.sda};
  assign m_axis_tuser  = {out_q.rvalid, out_q.kind};
  assign m_axis_tlast  = out_q.last;

endmodule
